// ----- src/byte_range_spec_parser_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the byte range parser
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef BYTE_RANGE_SPEC_PARSER_CORE_MACROS_SVH
`define BYTE_RANGE_SPEC_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/brsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte range parser package
// Widths, character constants, token and phase types shared by the parser.
// ----------------------------------------------------------------------------
package brsp_pkg;

  // Width of the start and end accumulators.
  localparam int OFF_W   = 48;
  // Width of the signed offset fields of a result.
  localparam int FIELD_W = 49;

  // Depth of the token queue between the classifier and the parser.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2d;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [1:0] OUT_MORE  = 2'd0;
  localparam logic [1:0] OUT_LAST  = 2'd1;
  localparam logic [1:0] OUT_UNSAT = 2'd2;

  localparam logic signed [FIELD_W-1:0] FIELD_NONE = '1;

  typedef enum logic [2:0] {
    CH_SPACE,
    CH_DASH,
    CH_COMMA,
    CH_NUL,
    CH_DIGIT,
    CH_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } token_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_START,
    PH_AFT_START,
    PH_AFT_DASH,
    PH_END_FIRST,
    PH_END,
    PH_AFT_END,
    PH_SWALLOW
  } phase_t;

  // Zero-extends or truncates an accumulator into a result field.
  function automatic logic signed [FIELD_W-1:0] to_field(input logic [OFF_W-1:0] a);
    logic [OFF_W+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, a};
    return w[FIELD_W-1:0];
  endfunction

endpackage

// ----- src/brsp_front.sv -----
// ----------------------------------------------------------------------------
// Byte range parser front end
// Classifies each incoming character and queues the resulting token.
// ----------------------------------------------------------------------------
module brsp_front
  import brsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] value_byte,
  output logic       tok_valid,
  output token_t     tok,
  input  logic       tok_pop
);

  token_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  token_t               tok_in;
  logic                 push;
  logic                 pop;

  always_comb begin
    tok_in.digit = 4'(value_byte - CHAR_0);
    if (value_byte == CHAR_SPACE) begin
      tok_in.cls = CH_SPACE;
    end else if (value_byte == CHAR_DASH) begin
      tok_in.cls = CH_DASH;
    end else if (value_byte == CHAR_COMMA) begin
      tok_in.cls = CH_COMMA;
    end else if (value_byte == CHAR_NUL) begin
      tok_in.cls = CH_NUL;
    end else if (value_byte inside {[CHAR_0:CHAR_9]}) begin
      tok_in.cls = CH_DIGIT;
    end else begin
      tok_in.cls = CH_OTHER;
    end
  end

  assign in_stall  = (count == Q_CNT_W'(Q_DEPTH));
  assign tok_valid = (count != '0);
  assign tok       = entries[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = tok_pop && tok_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/brsp_back.sv -----
// ----------------------------------------------------------------------------
// Byte range parser back end
// Runs the range grammar on queued tokens and holds the result register.
// ----------------------------------------------------------------------------
`include "byte_range_spec_parser_core_macros.svh"

module brsp_back
  import brsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tok_valid,
  input  token_t                    tok,
  output logic                      tok_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] range_start,
  output logic signed [FIELD_W-1:0] range_end,
  output logic signed [FIELD_W-1:0] suffix_length,
  output logic [1:0]                outcome
);

  phase_t             phase;
  phase_t             phase_next;
  logic [OFF_W-1:0]   start_accum;
  logic [OFF_W-1:0]   start_accum_next;
  logic [OFF_W-1:0]   end_accum;
  logic [OFF_W-1:0]   end_accum_next;
  logic               suffix_seen;
  logic               suffix_seen_next;

  logic               step;
  logic [OFF_W-1:0]   mac_in;
  logic [OFF_W+3:0]   mac_sum;
  logic               mac_ok;
  logic               start_gt_end;

  logic               do_fail;
  logic               do_done;
  logic               emit;
  logic signed [FIELD_W-1:0] emit_start;
  logic signed [FIELD_W-1:0] emit_end;
  logic signed [FIELD_W-1:0] emit_suffix;
  logic [1:0]         emit_outcome;
  logic [1:0]         range_code;
  logic               is_sep;

  assign tok_pop = tok_valid && (!emit || !out_valid || !out_stall);
  assign step    = tok_pop;

  // One shared multiply-by-ten and add; overflow when any bit lands above the accumulator.
  assign mac_in  = (phase == PH_END) ? end_accum : start_accum;
  assign mac_sum = ({4'b0, mac_in} << 3) + ({4'b0, mac_in} << 1) + (OFF_W + 4)'(tok.digit);
  assign mac_ok  = (mac_sum[OFF_W+3:OFF_W] == 4'b0);
  assign start_gt_end = (start_accum > end_accum);

  assign is_sep     = (tok.cls == CH_COMMA) || (tok.cls == CH_NUL);
  assign range_code = (tok.cls == CH_NUL) ? OUT_LAST : OUT_MORE;

  // Datapath and result decisions.
  always_comb begin
    start_accum_next = start_accum;
    end_accum_next   = end_accum;
    suffix_seen_next = suffix_seen;
    do_fail          = 1'b0;
    do_done          = 1'b0;
    emit             = 1'b0;
    emit_start       = '0;
    emit_end         = '0;
    emit_suffix      = '0;
    emit_outcome     = OUT_UNSAT;
    case (phase)
      PH_LEAD: begin
        if (tok.cls == CH_DASH) begin
          suffix_seen_next = 1'b1;
        end else if (tok.cls == CH_DIGIT) begin
          start_accum_next = OFF_W'(tok.digit);
        end else if (tok.cls != CH_SPACE) begin
          do_fail = 1'b1;
        end
      end
      PH_START: begin
        if (tok.cls == CH_DIGIT) begin
          if (mac_ok) begin
            start_accum_next = mac_sum[OFF_W-1:0];
          end else begin
            do_fail = 1'b1;
          end
        end else if (tok.cls != CH_SPACE && tok.cls != CH_DASH) begin
          do_fail = 1'b1;
        end
      end
      PH_AFT_START: begin
        if (tok.cls != CH_SPACE && tok.cls != CH_DASH) begin
          do_fail = 1'b1;
        end
      end
      PH_AFT_DASH: begin
        if (is_sep) begin
          do_done      = 1'b1;
          emit         = 1'b1;
          emit_start   = to_field(start_accum);
          emit_end     = FIELD_NONE;
          emit_suffix  = FIELD_NONE;
          emit_outcome = range_code;
        end else if (tok.cls == CH_DIGIT) begin
          end_accum_next = OFF_W'(tok.digit);
        end else if (tok.cls != CH_SPACE) begin
          do_fail = 1'b1;
        end
      end
      PH_END_FIRST: begin
        if (tok.cls == CH_DIGIT) begin
          end_accum_next = OFF_W'(tok.digit);
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_END, PH_AFT_END: begin
        if (phase == PH_END && tok.cls == CH_DIGIT) begin
          if (mac_ok) begin
            end_accum_next = mac_sum[OFF_W-1:0];
          end else begin
            do_fail = 1'b1;
          end
        end else if (is_sep) begin
          if (suffix_seen) begin
            do_done      = 1'b1;
            emit         = 1'b1;
            emit_start   = FIELD_NONE;
            emit_end     = FIELD_NONE;
            emit_suffix  = to_field(end_accum);
            emit_outcome = range_code;
          end else if (start_gt_end) begin
            do_fail = 1'b1;
          end else begin
            do_done      = 1'b1;
            emit         = 1'b1;
            emit_start   = to_field(start_accum);
            emit_end     = to_field(end_accum);
            emit_suffix  = FIELD_NONE;
            emit_outcome = range_code;
          end
        end else if (tok.cls != CH_SPACE) begin
          do_fail = 1'b1;
        end
      end
      PH_SWALLOW: begin
        do_done = (tok.cls == CH_NUL);
      end
      default: begin
        do_fail = 1'b1;
      end
    endcase
    if (do_fail) begin
      emit         = 1'b1;
      emit_start   = '0;
      emit_end     = '0;
      emit_suffix  = '0;
      emit_outcome = OUT_UNSAT;
    end
    if (do_fail || do_done) begin
      start_accum_next = '0;
      end_accum_next   = '0;
      suffix_seen_next = 1'b0;
    end
  end

  // Phase transitions.
  always_comb begin
    phase_next = phase;
    if (do_fail) begin
      phase_next = (tok.cls == CH_NUL) ? PH_LEAD : PH_SWALLOW;
    end else if (do_done) begin
      phase_next = PH_LEAD;
    end else begin
      case (phase)
        PH_LEAD: begin
          if (tok.cls == CH_DASH) begin
            phase_next = PH_END_FIRST;
          end else if (tok.cls == CH_DIGIT) begin
            phase_next = PH_START;
          end
        end
        PH_START: begin
          if (tok.cls == CH_SPACE) begin
            phase_next = PH_AFT_START;
          end else if (tok.cls == CH_DASH) begin
            phase_next = PH_AFT_DASH;
          end
        end
        PH_AFT_START: begin
          if (tok.cls == CH_DASH) begin
            phase_next = PH_AFT_DASH;
          end
        end
        PH_AFT_DASH, PH_END_FIRST: begin
          if (tok.cls == CH_DIGIT) begin
            phase_next = PH_END;
          end
        end
        PH_END: begin
          if (tok.cls == CH_SPACE) begin
            phase_next = PH_AFT_END;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      start_accum <= '0;
      end_accum   <= '0;
      suffix_seen <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      start_accum <= start_accum_next;
      end_accum   <= end_accum_next;
      suffix_seen <= suffix_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      range_start   <= emit_start;
      range_end     <= emit_end;
      suffix_length <= emit_suffix;
      outcome       <= emit_outcome;
    end
  end

  `BRSP_ASSERT_SAME(a_unsat_zero, clk, rst, out_valid && outcome == OUT_UNSAT,
    range_start == '0 && range_end == '0 && suffix_length == '0,
    "not-satisfiable result carries nonzero offsets")
  `BRSP_ASSERT_SAME(a_swallow_clear, clk, rst, phase == PH_SWALLOW,
    start_accum == '0 && end_accum == '0 && !suffix_seen,
    "range state not cleared while swallowing")
  `BRSP_ASSERT_NEXT(a_emit_phase, clk, rst, step && emit,
    phase == PH_LEAD || phase == PH_SWALLOW,
    "parser not restarted after a result")
  `BRSP_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && out_stall,
    out_valid && $stable(outcome),
    "stalled result dropped or changed")

endmodule

// ----- src/byte_range_spec_parser_core.sv -----
// ----------------------------------------------------------------------------
// Byte range parser core
// Parses an HTTP byte-range value, one character per request, into ranges.
// ----------------------------------------------------------------------------
// The block takes the characters that follow the "bytes=" prefix of a Range
// value, one character per input request, and a zero byte ends the value.
// It sustains one character per clock cycle while the queue is not full: the
// front end classifies each character and writes it into a two-entry token
// queue, and the back end consumes one token per cycle, except a token that
// gives a result while the output register is full and stalled, with a single
// shared multiply-by-ten adder for the start and end offsets. A range result
// is registered as its closing comma or zero byte leaves the queue. The output
// register lets the parser keep consuming characters that give no result
// while a finished result waits; the input stalls only when the queue is full.
// Spaces are skipped, and three forms are recognized: "start-end", "start-"
// (end reported as -1) and "-n" (start and end -1, suffix length n). A value
// that is malformed, has a start above its end or overflows a 48-bit offset
// gives one not-satisfiable result with zero offsets, after which characters
// are dropped up to and including the terminating zero byte.
module byte_range_spec_parser_core
  import brsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                value_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] range_start,
  output logic signed [FIELD_W-1:0] range_end,
  output logic signed [FIELD_W-1:0] suffix_length,
  output logic [1:0]                outcome
);

  // Classified characters waiting for the parser.
  logic   tok_valid;
  token_t tok;
  logic   tok_pop;

  // Front end: character classification and the token queue.
  brsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value_byte (value_byte),
    .tok_valid  (tok_valid),
    .tok        (tok),
    .tok_pop    (tok_pop)
  );

  // Back end: range grammar, offset accumulators and the result register.
  // A token that gives a result is consumed only when the result register can
  // take a new request; other tokens go through while a result waits, so a
  // stalled result never blocks more than the queue depth of input.
  brsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tok_valid     (tok_valid),
    .tok           (tok),
    .tok_pop       (tok_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .range_start   (range_start),
    .range_end     (range_end),
    .suffix_length (suffix_length),
    .outcome       (outcome)
  );

endmodule
